FILE: sv/lr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_pkg: shared types and helpers for the line rasterizer
// Holds the coordinate widths, the line state record and the per-beat
// pixel record that pass between the stepper and the top level.
// ----------------------------------------------------------------------------
package lr_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int COLOR_BITS = 24;

    // Opcode values of an input beat.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;

    // Everything the stepper keeps about the line being drawn.
    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t target_x;
        coord_t target_y;
        coord_t delta_x;
        coord_t delta_y;
        logic   step_x_neg;
        logic   step_y_neg;
        logic   x_major;
        err_t   error_term;
        logic   line_active;
    } line_state_t;

    // Pixel produced for one input beat, before the color is attached.
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   valid;
        logic   last;
    } pixel_t;

    // Move a coordinate one unit up or down, wrapping at the coordinate width.
    function automatic coord_t move_one(input coord_t v, input logic neg);
        coord_t r;
        if (neg)
        begin
            r = v - coord_t'(1);
        end
        else
        begin
            r = v + coord_t'(1);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/lr_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lr_step: one Bresenham step
// Combinational logic that takes the line state and one input beat and
// returns the next line state and the pixel that the beat produces.
// ----------------------------------------------------------------------------
module lr_step (
    input  wire logic                          opcode,
    input  wire lr_pkg::coord_t                start_x,
    input  wire lr_pkg::coord_t                start_y,
    input  wire lr_pkg::coord_t                end_x,
    input  wire lr_pkg::coord_t                end_y,
    input  wire lr_pkg::line_state_t           state,
    output lr_pkg::line_state_t                state_next,
    output lr_pkg::pixel_t                     pixel
);

    // Major and minor deltas of the active line, wide enough for twice the value.
    logic [lr_pkg::ERR_BITS:0] major2;
    logic [lr_pkg::ERR_BITS:0] minor2;
    logic signed [lr_pkg::ERR_BITS:0] err_dec;
    logic signed [lr_pkg::ERR_BITS:0] err_fix;
    logic minor_step;
    lr_pkg::coord_t adv_x;
    lr_pkg::coord_t adv_y;

    // Setup values for a start beat.
    logic sx_neg;
    logic sy_neg;
    lr_pkg::coord_t dx;
    lr_pkg::coord_t dy;
    logic xm;
    logic single;

    // Start beat: directions, deltas and major axis from the endpoints.
    always_comb
    begin
        sx_neg = end_x < start_x;
        sy_neg = end_y < start_y;
        dx     = sx_neg ? (start_x - end_x) : (end_x - start_x);
        dy     = sy_neg ? (start_y - end_y) : (end_y - start_y);
        xm     = dx > dy;
        single = (start_x == end_x) && (start_y == end_y);
    end

    // Advance beat: error update and the minor-axis step.
    always_comb
    begin
        if (state.x_major)
        begin
            major2 = {2'b00, state.delta_x, 1'b0};
            minor2 = {2'b00, state.delta_y, 1'b0};
        end
        else
        begin
            major2 = {2'b00, state.delta_y, 1'b0};
            minor2 = {2'b00, state.delta_x, 1'b0};
        end
        err_dec    = {state.error_term[lr_pkg::ERR_BITS-1], state.error_term}
                     - $signed(minor2);
        minor_step = err_dec[lr_pkg::ERR_BITS];
        err_fix    = minor_step ? (err_dec + $signed(major2)) : err_dec;

        if (state.x_major)
        begin
            adv_x = lr_pkg::move_one(state.cur_x, state.step_x_neg);
            adv_y = minor_step ? lr_pkg::move_one(state.cur_y, state.step_y_neg)
                               : state.cur_y;
        end
        else
        begin
            adv_y = lr_pkg::move_one(state.cur_y, state.step_y_neg);
            adv_x = minor_step ? lr_pkg::move_one(state.cur_x, state.step_x_neg)
                               : state.cur_x;
        end
    end

    // Pick the result by opcode; an advance on an idle line leaves state alone.
    always_comb
    begin
        state_next = state;
        pixel      = '0;
        if (opcode == lr_pkg::OP_START)
        begin
            state_next.step_x_neg  = sx_neg;
            state_next.step_y_neg  = sy_neg;
            state_next.delta_x     = dx;
            state_next.delta_y     = dy;
            state_next.x_major     = xm;
            state_next.error_term  = lr_pkg::err_t'({2'b00, (xm ? dx : dy)});
            state_next.cur_x       = start_x;
            state_next.cur_y       = start_y;
            state_next.target_x    = end_x;
            state_next.target_y    = end_y;
            state_next.line_active = !single;
            pixel.x     = start_x;
            pixel.y     = start_y;
            pixel.valid = 1'b1;
            pixel.last  = single;
        end
        else if (state.line_active)
        begin
            state_next.cur_x       = adv_x;
            state_next.cur_y       = adv_y;
            state_next.error_term  = err_fix[lr_pkg::ERR_BITS-1:0];
            state_next.line_active = state.x_major ? (adv_x != state.target_x)
                                                   : (adv_y != state.target_y);
            pixel.x     = adv_x;
            pixel.y     = adv_y;
            pixel.valid = 1'b1;
            pixel.last  = !state_next.line_active;
        end
    end

endmodule
`default_nettype wire

FILE: sv/line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line stepper
// A start beat loads two endpoints and returns the first pixel; each advance
// beat returns the next pixel toward the end point, flagged last at the end.
//
// Channels: input beats (opcode and endpoints) on in_valid/in_ready, one
// result beat per input beat on out_valid/out_ready, and the drawing color
// on cfg_valid/cfg_data, which is always ready.
// Path: an accepted beat is held in the input register, then stepped into
// the output register, from which its result is offered; while the output
// register is full and not drained, the beat waits in the input register.
// Throughput: one beat per clock while out_ready is high. The line state
// is updated by the combinational stepper, so consecutive beats need no gap.
// Stall: when out_ready is low the result holds in the output register, the
// next beat waits in the input register, and in_ready drops only once both
// are full.
// Reset: clears the color, all line state (no line active) and the valid
// flags of both register stages.
// ----------------------------------------------------------------------------
module line_rasterizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [11:0] start_x,
    input  wire logic [11:0] start_y,
    input  wire logic [11:0] end_x,
    input  wire logic [11:0] end_y,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      pixel_x,
    output logic [11:0]      pixel_y,
    output logic [23:0]      pixel_color,
    output logic             pixel_valid,
    output logic             last_pixel,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data
);

    logic [lr_pkg::COLOR_BITS-1:0] color_reg;

    // Input register stage.
    logic            in_vld_reg;
    logic            op_reg;
    lr_pkg::coord_t  sx_reg;
    lr_pkg::coord_t  sy_reg;
    lr_pkg::coord_t  ex_reg;
    lr_pkg::coord_t  ey_reg;

    // Line state and the stepper outputs.
    lr_pkg::line_state_t state_reg;
    lr_pkg::line_state_t state_next;
    lr_pkg::pixel_t      pix;

    // Output register stage.
    logic                          out_vld_reg;
    lr_pkg::pixel_t                pix_reg;
    logic [lr_pkg::COLOR_BITS-1:0] pcolor_reg;

    logic advance;

    // A beat moves on when the output register is empty or being drained.
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    // Color register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else if (cfg_valid)
        begin
            color_reg <= cfg_data;
        end
    end

    // Input register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Input register: payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= opcode;
            sx_reg <= start_x;
            sy_reg <= start_y;
            ex_reg <= end_x;
            ey_reg <= end_y;
        end
    end

    // Stepper.
    lr_step u_step (
        .opcode     (op_reg),
        .start_x    (sx_reg),
        .start_y    (sy_reg),
        .end_x      (ex_reg),
        .end_y      (ey_reg),
        .state      (state_reg),
        .state_next (state_next),
        .pixel      (pix)
    );

    // Line state, updated as each beat leaves the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Output register: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // Output register: payload, with the color attached to emitted pixels.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg    <= pix;
            pcolor_reg <= pix.valid ? color_reg : '0;
        end
    end

    assign out_valid   = out_vld_reg;
    assign pixel_x     = pix_reg.x;
    assign pixel_y     = pix_reg.y;
    assign pixel_color = pcolor_reg;
    assign pixel_valid = pix_reg.valid;
    assign last_pixel  = pix_reg.last;

endmodule
`default_nettype wire
